// ===== hw/rtl/quadratic_probe_hash_table_macros.svh =====
// assertion macros for the quadratic probe hash table checker
// no dependencies; included by files that carry concurrent assertions
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// consequent checked in the same cycle, off during reset
`define QPHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent, off during reset
`define QPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent, also live during reset
`define QPHT_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qpht_pkg.sv =====
// shared widths, request and slot status codes for the quadratic probe hash table
// no dependencies
`timescale 1ns / 1ps

package qpht_pkg;

    localparam int SW  = 9;   // table size and slot arithmetic width
    localparam int KW  = 31;  // key width
    localparam int VW  = 32;  // value width
    localparam int STW = 2;   // slot status width

    localparam int          CAPACITY_DEF   = 256;
    localparam logic [SW-1:0] TABLE_SIZE_RST = SW'(256);

    // remainder unit: dividend padded to a multiple of the bits per cycle
    localparam int MOD_DVD_W = 32;
    localparam int MOD_BPC   = 4;
    localparam int MOD_CYC   = MOD_DVD_W / MOD_BPC;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [STW-1:0] SLOT_NEVER   = 2'd0;
    localparam logic [STW-1:0] SLOT_CLEARED = 2'd1;
    localparam logic [STW-1:0] SLOT_LIVE    = 2'd2;

endpackage

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// open-addressing hash table with quadratic probing over one slot memory
// depends on qpht_pkg and qpht_mod
// flow: an input transfer starts the key remainder, then the probe walk
//   issues one slot read per cycle until the request is settled
// throughput: one request at a time; the next is taken once the result is queued
// reset: a clearing pass writes every slot, with s_axis_tready low
`timescale 1ns / 1ps

module quadratic_probe_hash_table #(
    parameter int CAPACITY = qpht_pkg::CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: table_size
    input  logic                   i_cfg_we,
    input  logic [qpht_pkg::SW-1:0] i_cfg_wdata,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [63:0]            s_axis_tdata,  // key [30:0], value [62:31], zero pad
    input  logic [1:0]             s_axis_tuser,  // kind [1:0]
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,  // value_out [31:0]
    output logic [0:0]             m_axis_tuser   // ok [0]
);
    import qpht_pkg::*;

    localparam int AW      = $clog2(CAPACITY);
    localparam int MW      = STW + KW + VW;
    localparam int CAP_LIM = (CAPACITY > 511) ? 511 : CAPACITY;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_PROBE = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    // slot memory: {status, key, value}
    logic [MW-1:0] r_mem [CAPACITY];
    logic [MW-1:0] r_rd_data;

    t_state        r_state, n_state;
    logic [AW:0]   r_clr_cnt, n_clr_cnt;
    logic [SW-1:0] r_table_size;
    logic          r_rd_vld, n_rd_vld;
    logic          r_m_vld, n_m_vld;

    logic [1:0]    r_kind, n_kind;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_val, n_val;
    logic [SW-1:0] r_size, n_size;
    logic [SW:0]   r_lim, n_lim;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_inc, n_inc;
    logic [SW:0]   r_iss, n_iss;
    logic [SW:0]   r_chk, n_chk;
    logic [SW-1:0] r_rd_slot, n_rd_slot;
    logic          r_res_ok, n_res_ok;
    logic [VW-1:0] r_res_val, n_res_val;
    logic          r_m_ok, n_m_ok;
    logic [VW-1:0] r_m_val, n_m_val;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata;

    logic          mod_start, mod_done;
    logic [SW-1:0] mod_rem;

    logic [SW-1:0]  eff_size;
    logic [STW-1:0] rd_st;
    logic [KW-1:0]  rd_key;
    logic [VW-1:0]  rd_val;
    logic           key_eq, is_live, is_clr, is_ins, is_lkp;
    logic           take, hit, stop_miss, last, finish;
    logic [SW:0]    sum_slot, sum_inc;
    logic [SW-1:0]  slot_nx, inc_nx;
    logic           s_kind_ok;

    qpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (s_axis_tdata[KW-1:0]),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // a size of zero counts as one, and the size is clamped to the store
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = SW'(1);
        end else if (r_table_size > SW'(CAP_LIM)) begin
            eff_size = SW'(CAP_LIM);
        end else begin
            eff_size = r_table_size;
        end
    end

    assign rd_st   = r_rd_data[MW-1 -: STW];
    assign rd_key  = r_rd_data[VW +: KW];
    assign rd_val  = r_rd_data[VW-1:0];
    assign key_eq  = (rd_key == r_key);
    assign is_live = (rd_st == SLOT_LIVE);
    assign is_clr  = (rd_st == SLOT_CLEARED);
    assign is_ins  = (r_kind == KIND_INSERT);
    assign is_lkp  = (r_kind == KIND_LOOKUP);

    assign take      = !is_live || key_eq;
    assign hit       = is_live && key_eq;
    // status three reads as never used
    assign stop_miss = (is_clr && key_eq) || (!is_live && !is_clr);
    assign last      = (r_chk == r_lim - (SW+1)'(1));
    assign finish    = r_rd_vld && (is_ins ? (take || last) : (hit || stop_miss || last));

    // next probe slot: add (2p+1) mod size, then step the increment by two
    assign sum_slot = {1'b0, r_slot} + {1'b0, r_inc};
    assign slot_nx  = (sum_slot >= {1'b0, r_size}) ? SW'(sum_slot - {1'b0, r_size})
                                                   : sum_slot[SW-1:0];
    assign sum_inc  = {1'b0, r_inc} + (SW+1)'(2);
    assign inc_nx   = (r_size == SW'(1)) ? '0 :
                      (sum_inc >= {1'b0, r_size}) ? SW'(sum_inc - {1'b0, r_size})
                                                  : sum_inc[SW-1:0];

    assign s_kind_ok = (s_axis_tuser == KIND_LOOKUP) || (s_axis_tuser == KIND_INSERT) ||
                       (s_axis_tuser == KIND_DELETE);

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_rd_vld  = 1'b0;
        n_m_vld   = r_m_vld && !m_axis_tready;
        n_kind    = r_kind;
        n_key     = r_key;
        n_val     = r_val;
        n_size    = r_size;
        n_lim     = r_lim;
        n_slot    = r_slot;
        n_inc     = r_inc;
        n_iss     = r_iss;
        n_chk     = r_chk;
        n_rd_slot = r_rd_slot;
        n_res_ok  = r_res_ok;
        n_res_val = r_res_val;
        n_m_ok    = r_m_ok;
        n_m_val   = r_m_val;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_rd_slot);
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = AW'(r_slot);
        mod_start = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt[AW-1:0];
                n_clr_cnt = r_clr_cnt + (AW+1)'(1);
                if (r_clr_cnt == (AW+1)'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind = s_axis_tuser;
                    n_key  = s_axis_tdata[KW-1:0];
                    n_val  = s_axis_tdata[KW +: VW];
                    n_size = eff_size;
                    n_lim  = (s_axis_tuser == KIND_INSERT) ? {1'b0, eff_size} + (SW+1)'(1)
                                                           : {1'b0, eff_size};
                    if (s_kind_ok) begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end else begin
                        n_res_ok  = 1'b0;
                        n_res_val = '0;
                        n_state   = S_RESP;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_slot  = mod_rem;
                    n_inc   = (r_size == SW'(1)) ? '0 : SW'(1);
                    n_iss   = '0;
                    n_chk   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_rd_vld) begin
                    n_chk = r_chk + (SW+1)'(1);
                end
                if (finish) begin
                    // writes happen only at the end of a walk, so no read can see them
                    n_res_ok  = is_ins ? take : hit;
                    n_res_val = (is_lkp && hit) ? rd_val : '0;
                    n_state   = S_RESP;
                    if (is_ins && take) begin
                        mem_we    = 1'b1;
                        mem_wdata = {SLOT_LIVE, r_key, r_val};
                    end else if ((r_kind == KIND_DELETE) && hit) begin
                        mem_we    = 1'b1;
                        mem_wdata = {SLOT_CLEARED, rd_key, rd_val};
                    end
                end else if (r_iss < r_lim) begin
                    mem_re    = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_slot = r_slot;
                    n_slot    = slot_nx;
                    n_inc     = inc_nx;
                    n_iss     = r_iss + (SW+1)'(1);
                end
            end
            S_RESP: begin
                if (!r_m_vld || m_axis_tready) begin
                    n_m_vld = 1'b1;
                    n_m_ok  = r_res_ok;
                    n_m_val = r_res_val;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_table_size <= TABLE_SIZE_RST;
            r_rd_vld     <= 1'b0;
            r_m_vld      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_rd_vld  <= n_rd_vld;
            r_m_vld   <= n_m_vld;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_val     <= n_val;
        r_size    <= n_size;
        r_lim     <= n_lim;
        r_slot    <= n_slot;
        r_inc     <= n_inc;
        r_iss     <= n_iss;
        r_chk     <= n_chk;
        r_rd_slot <= n_rd_slot;
        r_res_ok  <= n_res_ok;
        r_res_val <= n_res_val;
        r_m_ok    <= n_m_ok;
        r_m_val   <= n_m_val;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_m_vld;
    assign m_axis_tdata    = r_m_val;
    assign m_axis_tuser[0] = r_m_ok;

endmodule

// ===== hw/rtl/qpht_mod.sv =====
// key modulo table size, restoring remainder, four dividend bits per cycle
// depends on qpht_pkg
`timescale 1ns / 1ps

module qpht_mod (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [qpht_pkg::KW-1:0] i_dividend,
    input  logic [qpht_pkg::SW-1:0] i_divisor,
    output logic                  o_done,
    output logic [qpht_pkg::SW-1:0] o_rem
);
    import qpht_pkg::*;

    localparam int CW = $clog2(MOD_CYC);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [MOD_DVD_W-1:0] r_dvd;
    logic [SW-1:0]        r_div;
    logic [SW-1:0]        r_rem;

    logic [MOD_DVD_W-1:0] n_dvd;
    logic [SW-1:0]        n_rem;

    // one remainder step per dividend bit, msb first
    always_comb begin
        logic [SW:0] t;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int b = 0; b < MOD_BPC; b++) begin
            t     = {n_rem, n_dvd[MOD_DVD_W-1]};
            n_dvd = {n_dvd[MOD_DVD_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(MOD_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= MOD_DVD_W'(i_dividend);
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/qpht_chk.sv =====
// port-level assertions for the quadratic probe hash table, bound to the top level
// depends on quadratic_probe_hash_table_macros.svh
`timescale 1ns / 1ps
`include "quadratic_probe_hash_table_macros.svh"

module qpht_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result keeps its contents
    `QPHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // a nonzero value comes only with ok set, as only a lookup hit returns a value
    `QPHT_ASSERT_SAME(a_value_needs_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata != 32'd0), m_axis_tuser[0], "nonzero value without ok")

    // a request in flight blocks the next transfer
    `QPHT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

    // reset starts the clearing pass with both sides quiet
    `QPHT_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !s_axis_tready && !m_axis_tvalid, "activity right after reset")

endmodule

bind quadratic_probe_hash_table qpht_chk u_qpht_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_quadratic_probe_hash_table.sv =====
// self-checking testbench for quadratic_probe_hash_table: lookup/insert/delete requests
// depends on qpht_pkg and the block's rtl; a scoreboard class predicts every answer
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;

    import qpht_pkg::*;

    localparam int         CAP         = CAPACITY_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         IDLE_PCT    = 18;
    localparam int         DRAIN_CYC   = 300;

    typedef struct {
        logic          ok;
        logic [VW-1:0] value;
    } t_answer;

    class probe_table_checker;
        logic [STW-1:0] slot_status [CAP];
        logic [KW-1:0]  slot_key [CAP];
        logic [VW-1:0]  slot_value [CAP];
        logic [SW-1:0]  table_size;
        t_answer        pending_answers [$];
        int             errors;
        int             hits;
        int             kind_count [4];

        function new();
            table_size = TABLE_SIZE_RST;
            errors     = 0;
            hits       = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
            foreach (slot_status[s]) begin
                slot_status[s] = SLOT_NEVER;
                slot_key[s]    = '0;
                slot_value[s]  = '0;
            end
        endfunction

        // slots actually in use: zero counts as one, oversize clamps to capacity
        function int span();
            if (table_size == 0) return 1;
            if (table_size > CAP) return CAP;
            return int'(table_size);
        endfunction

        function int probe_slot(logic [KW-1:0] key, int p, int size);
            longint unsigned sum;
            sum = longint'(key) + longint'(p) * longint'(p);
            return int'(sum % longint'(size));
        endfunction

        // index of the live slot holding key, -1 on a miss
        function int find_live(logic [KW-1:0] key);
            int size;
            int s;
            size = span();
            for (int p = 0; p < size; p++) begin
                s = probe_slot(key, p, size);
                if (slot_status[s] == SLOT_LIVE) begin
                    if (slot_key[s] == key) return s;
                end else if (slot_status[s] == SLOT_CLEARED) begin
                    if (slot_key[s] == key) return -1;
                end else begin
                    return -1;
                end
            end
            return -1;
        endfunction

        function void take_request(logic [1:0] kind, logic [KW-1:0] key, logic [VW-1:0] value);
            t_answer a;
            int      s;
            int      size;
            a.ok    = 1'b0;
            a.value = '0;
            size    = span();
            kind_count[kind]++;
            case (kind)
                KIND_LOOKUP: begin
                    s = find_live(key);
                    if (s >= 0) begin
                        a.ok    = 1'b1;
                        a.value = slot_value[s];
                    end
                end
                KIND_INSERT: begin
                    for (int p = 0; p <= size; p++) begin
                        s = probe_slot(key, p, size);
                        if (slot_status[s] != SLOT_LIVE || slot_key[s] == key) begin
                            slot_status[s] = SLOT_LIVE;
                            slot_key[s]    = key;
                            slot_value[s]  = value;
                            a.ok           = 1'b1;
                            break;
                        end
                    end
                end
                KIND_DELETE: begin
                    s = find_live(key);
                    if (s >= 0) begin
                        slot_status[s] = SLOT_CLEARED;
                        a.ok           = 1'b1;
                    end
                end
                default: ;
            endcase
            pending_answers.push_back(a);
        endfunction

        function void check_answer(logic ok, logic [VW-1:0] value);
            t_answer a;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result ok=%0b value=%08h", $time, ok, value);
                errors++;
                return;
            end
            a = pending_answers.pop_front();
            if (ok !== a.ok) begin
                $display("%0t: ok mismatch, expected %0b actual %0b", $time, a.ok, ok);
                errors++;
            end
            if (value !== a.value) begin
                $display("%0t: value mismatch, expected %08h actual %08h", $time, a.value, value);
                errors++;
            end
            if (ok === 1'b1 && a.ok) hits++;
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [SW-1:0]  i_cfg_wdata;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [63:0]    s_axis_tdata;   // key [30:0], value [62:31], zero pad
    logic [1:0]     s_axis_tuser;   // kind [1:0]
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [31:0]    m_axis_tdata;   // value_out [31:0]
    logic [0:0]     m_axis_tuser;   // ok [0]

    probe_table_checker table_chk;
    bit                 quiet;
    int                 sizes_used;

    quadratic_probe_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_request(logic [1:0] kind, logic [KW-1:0] key, logic [VW-1:0] value);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, value, key};
        do @(posedge i_clk); while (!s_axis_tready);
        table_chk.take_request(kind, key, value);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (table_chk.pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_size(logic [SW-1:0] size);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(negedge i_clk);
        i_cfg_we             <= 1'b0;
        table_chk.table_size  = size;
        sizes_used++;
    endtask

    // mostly keys near the home range so chains collide, some far aliases and full-width keys
    function automatic logic [KW-1:0] pick_key();
        int size;
        int r;
        size = table_chk.span();
        r    = $urandom_range(0, 99);
        if (r < 60) return KW'($urandom_range(0, 3 * size));
        if (r < 85) return KW'($urandom_range(0, size) + size * $urandom_range(0, 1000));
        return KW'($urandom);
    endfunction

    task automatic random_requests(int count);
        int         r;
        logic [1:0] kind;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 40)      kind = KIND_INSERT;
            else if (r < 75) kind = KIND_LOOKUP;
            else if (r < 95) kind = KIND_DELETE;
            else             kind = KIND_UNUSED;
            send_request(kind, pick_key(), $urandom);
        end
    endtask

    // result side: random backpressure, transfers checked at the rising edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                table_chk.check_answer(m_axis_tuser[0], m_axis_tdata);
        end
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          phase_size [8];
        int          phase_items [8];
        logic [31:0] max_val;
        table_chk     = new();
        quiet         = 1'b0;
        sizes_used    = 1;
        max_val       = '1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOOKUP;
        phase_size  = '{1, 0, 511, 7, 16, 300, 2, 256};
        phase_items = '{30, 25, 60, 50, 60, 80, 25, 70};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty miss, extremes, collisions, cleared slots, duplicate after delete
        send_request(KIND_LOOKUP, 0, 32'h1234_5678);
        send_request(KIND_INSERT, 0, max_val);
        send_request(KIND_LOOKUP, 0, 0);
        send_request(KIND_INSERT, {KW{1'b1}}, 0);
        send_request(KIND_LOOKUP, {KW{1'b1}}, 0);
        send_request(KIND_INSERT, 256, 32'hA5A5_5A5A);
        send_request(KIND_LOOKUP, 256, 0);
        send_request(KIND_DELETE, 0, 0);
        send_request(KIND_LOOKUP, 256, 0);
        send_request(KIND_LOOKUP, 0, 0);
        send_request(KIND_INSERT, 512, 32'h0000_0001);
        send_request(KIND_INSERT, 256, 32'h8000_0000);
        send_request(KIND_LOOKUP, 256, 0);
        send_request(KIND_DELETE, 0, 0);
        send_request(KIND_INSERT, 768, 32'h1111_1111);
        send_request(KIND_DELETE, 256, 0);
        send_request(KIND_INSERT, 768, 32'h2222_2222);
        send_request(KIND_LOOKUP, 768, 0);
        send_request(KIND_DELETE, 768, 0);
        send_request(KIND_LOOKUP, 768, 0);
        send_request(KIND_UNUSED, 512, max_val);
        send_request(KIND_DELETE, {KW{1'b1}}, max_val);
        send_request(KIND_LOOKUP, {KW{1'b1}}, 0);

        for (int i = 0; i < 8; i++) begin
            write_size(SW'(phase_size[i]));
            quiet = (phase_size[i] == 300);
            random_requests(phase_items[i]);
            quiet = 1'b0;
        end

        wait_idle();
        $display("covered %0d lookups, %0d inserts, %0d deletes, %0d unknown kinds",
                 table_chk.kind_count[KIND_LOOKUP], table_chk.kind_count[KIND_INSERT],
                 table_chk.kind_count[KIND_DELETE], table_chk.kind_count[KIND_UNUSED]);
        $display("over %0d table size settings, %0d successful answers, %0d mismatches",
                 sizes_used, table_chk.hits, table_chk.errors);
        if (table_chk.errors == 0 && table_chk.pending_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qpht_pkg.sv
hw/rtl/qpht_mod.sv
hw/rtl/quadratic_probe_hash_table.sv
hw/rtl/qpht_chk.sv
sim/tb_quadratic_probe_hash_table.sv
